// ----- hdl/slat_pkg.sv -----
// ----------------------------------------------------------------------------
// Sound level average threshold: shared package
// Widths, derived constants and the stage records that are passed between
// the modules of the sound level boxcar averager.
// ----------------------------------------------------------------------------
`default_nettype none

package slat_pkg;

    // Number of cells in the boxcar window.
    localparam int SAMPLE_DEPTH = 16;

    // Field widths.
    localparam int MV_W      = 12;
    localparam int LEVEL_W   = 12;
    localparam int THR_W     = 12;
    localparam int LEVEL_MAX = 3276;

    // Running sum and scaled threshold widths.
    localparam int DEPTH_LOG = $clog2(SAMPLE_DEPTH);
    localparam int SUM_W     = $clog2(LEVEL_MAX * SAMPLE_DEPTH + 1);
    localparam int THRS_W    = THR_W + DEPTH_LOG;

    // Reciprocal for the exact floor(sum / SAMPLE_DEPTH).
    // The shift leaves at least log2(SAMPLE_DEPTH) guard bits above the sum
    // width, so the rounded-up reciprocal gives the exact quotient.
    localparam int AVG_SHIFT = SUM_W + DEPTH_LOG;
    localparam int RECIP_W   = SUM_W + 2;
    localparam int PROD_W    = SUM_W + RECIP_W;
    localparam longint unsigned AVG_RECIP =
        ((64'd1 << AVG_SHIFT) + SAMPLE_DEPTH - 1) / SAMPLE_DEPTH;

    // Configuration port.
    localparam int CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLED   = 1'b0,
        CFG_THRESHOLD = 1'b1
    } t_cfg_index;

    typedef logic [LEVEL_W-1:0] t_level;
    typedef logic [SUM_W-1:0]   t_sum;
    typedef logic [THRS_W-1:0]  t_thr_scaled;

    // Converted request waiting to enter the cell chain.
    typedef struct packed {
        logic   store;
        t_level level;
    } t_s1;

    // Window state snapshot taken after the chain update.
    typedef struct packed {
        logic   accepted;
        t_level last_level;
        t_sum   sum;
    } t_s2;

endpackage

`default_nettype wire

// ----- hdl/slat_cell.sv -----
// ----------------------------------------------------------------------------
// Sound level average threshold: window cell
// Holds one stored level and passes it on to the next cell on every shift.
// ----------------------------------------------------------------------------
`default_nettype none

module slat_cell import slat_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_shift,
    input  t_level i_level,
    output t_level o_level
);

    t_level r_level;

    // The window starts empty, so every cell clears to zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
        end else if (i_shift) begin
            r_level <= i_level;
        end
    end

    assign o_level = r_level;

endmodule

`default_nettype wire

// ----- hdl/slat_ring.sv -----
// ----------------------------------------------------------------------------
// Sound level average threshold: window chain and running sum
// A row of cells forms the boxcar window. A stored level enters the first
// cell while the oldest leaves the last one, and the running sum follows.
// ----------------------------------------------------------------------------
`default_nettype none

module slat_ring import slat_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_load,
    input  logic i_s1_valid,
    input  t_s1  i_s1,
    output logic o_s2_valid,
    output t_s2  o_s2
);

    t_level w_tap [SAMPLE_DEPTH+1];
    logic   w_shift;
    t_sum   r_sum;
    t_sum   n_sum;
    logic   r_s2_valid;
    t_s2    r_s2;

    // The chain only moves for a request that is stored.
    assign w_shift  = i_load && i_s1_valid && i_s1.store;
    assign w_tap[0] = i_s1.level;

    for (genvar g = 0; g < SAMPLE_DEPTH; g++) begin : g_cell
        slat_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_level (w_tap[g]),
            .o_level (w_tap[g+1])
        );
    end

    // The new level replaces the oldest one in the sum.
    always_comb begin
        n_sum = r_sum;
        if (w_shift) begin
            n_sum = r_sum - SUM_W'(w_tap[SAMPLE_DEPTH]) + SUM_W'(i_s1.level);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else begin
            r_sum <= n_sum;
        end
    end

    // Snapshot of the window as the request leaves the chain stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (i_load) begin
            r_s2_valid <= i_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_s1_valid) begin
            r_s2.accepted   <= i_s1.store;
            r_s2.last_level <= i_s1.store ? i_s1.level : w_tap[1];
            r_s2.sum        <= n_sum;
        end
    end

    assign o_s2_valid = r_s2_valid;
    assign o_s2       = r_s2;

    // An empty sum means every cell, the oldest included, holds zero.
    a_sum_zero_oldest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sum == '0) |-> (w_tap[SAMPLE_DEPTH] == '0))
        else $error("running sum is zero while the oldest cell is not");

    // The sum never exceeds a full window of maximum levels.
    a_sum_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sum <= SUM_W'(LEVEL_MAX * SAMPLE_DEPTH))
        else $error("running sum beyond a full window of maximum levels");

    // Without a shift the sum must hold.
    a_sum_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_shift |=> $stable(r_sum))
        else $error("running sum changed without a stored level");

endmodule

`default_nettype wire

// ----- hdl/slat_avg.sv -----
// ----------------------------------------------------------------------------
// Sound level average threshold: average and threshold output stage
// Divides the running sum by the window depth with a reciprocal multiply,
// compares it against the scaled threshold and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module slat_avg import slat_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  logic        i_valid,
    input  t_s2         i_s2,
    input  t_thr_scaled i_thr_scaled,
    output logic        o_valid,
    output logic        o_accepted,
    output t_level      o_last_level,
    output t_level      o_average_level,
    output logic        o_over_threshold
);

    logic [PROD_W-1:0] w_prod;
    t_level            w_avg;
    logic              w_over;
    logic              r_valid;
    logic              r_accepted;
    t_level            r_last_level;
    t_level            r_avg;
    logic              r_over;

    // Exact floor division by the window depth.
    assign w_prod = PROD_W'(i_s2.sum) * PROD_W'(AVG_RECIP);
    assign w_avg  = LEVEL_W'(w_prod >> AVG_SHIFT);

    // Comparing the sum with threshold times depth is the exact average test.
    assign w_over = THRS_W'(i_s2.sum) > i_thr_scaled;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_valid) begin
            r_accepted   <= i_s2.accepted;
            r_last_level <= i_s2.last_level;
            r_avg        <= w_avg;
            r_over       <= w_over;
        end
    end

    assign o_valid          = r_valid;
    assign o_accepted       = r_accepted;
    assign o_last_level     = r_last_level;
    assign o_average_level  = r_avg;
    assign o_over_threshold = r_over;

endmodule

`default_nettype wire

// ----- hdl/sound_level_average_threshold.sv -----
// ----------------------------------------------------------------------------
// Sound level average threshold: top level
// Converts microphone readings to levels, keeps a boxcar window of the last
// stored levels and reports the average and a threshold flag per request.
// ----------------------------------------------------------------------------
// The block takes one request per clock while the input is not stalled and
// returns one result per request. Each request passes the registered
// stages in order: the millivolt-to-level converter register, the cell
// chain that shifts the window and updates the running sum, and the averaging
// multiplier register. The window cells clear at reset, so no clearing pass
// is needed and requests are taken from the first cycle after reset.
// Configuration writes are always ready and are meant to arrive only while
// no request is in flight.
`default_nettype none

module sound_level_average_threshold import slat_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [MV_W-1:0]      i_sample_mv,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_accepted,
    output logic [LEVEL_W-1:0]   o_last_level_q4,
    output logic [LEVEL_W-1:0]   o_average_level_q4,
    output logic                 o_over_threshold,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [THR_W-1:0]     i_cfg_data
);

    // Level = floor(mv * 4 / 5) through a rounded-up reciprocal of five.
    localparam int LVL_IN_W    = MV_W + 2;
    localparam int LVL_SHIFT   = LVL_IN_W + 3;
    localparam int LVL_RECIP   = ((1 << LVL_SHIFT) + 4) / 5;
    localparam int LVL_RECIP_W = $clog2(LVL_RECIP + 1);
    localparam int LVL_PROD_W  = LVL_IN_W + LVL_RECIP_W;

    logic                  r_enabled;
    t_thr_scaled           r_thr_scaled;
    logic                  r_s1_valid;
    t_s1                   r_s1;
    logic                  w_s2_valid;
    t_s2                   w_s2;
    logic                  w_adv1;
    logic                  w_adv2;
    logic                  w_adv3;
    logic                  w_accept;
    logic [LVL_IN_W-1:0]   w_mv4;
    logic [LVL_PROD_W-1:0] w_lvl_prod;
    t_level                w_level;

    // Configuration registers; the threshold is kept pre-scaled by the depth.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled    <= 1'b1;
            r_thr_scaled <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_ENABLED: begin
                    r_enabled <= i_cfg_data[0];
                end
                CFG_THRESHOLD: begin
                    r_thr_scaled <= THRS_W'(i_cfg_data) * THRS_W'(SAMPLE_DEPTH);
                end
                default: begin
                end
            endcase
        end
    end

    // Each stage moves when the stage after it is empty or moving.
    assign w_adv3     = !o_out_valid || !i_out_stall;
    assign w_adv2     = !w_s2_valid || w_adv3;
    assign w_adv1     = !r_s1_valid || w_adv2;
    assign o_in_stall = !w_adv1;
    assign w_accept   = i_in_valid && w_adv1;

    // Millivolt to 1/16 dB conversion.
    assign w_mv4      = {i_sample_mv, 2'b00};
    assign w_lvl_prod = LVL_PROD_W'(w_mv4) * LVL_PROD_W'(LVL_RECIP);
    assign w_level    = LEVEL_W'(w_lvl_prod >> LVL_SHIFT);

    // Converter register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_adv1) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1.store <= r_enabled;
            r_s1.level <= w_level;
        end
    end

    // Window chain and running sum.
    slat_ring u_ring (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_adv2),
        .i_s1_valid (r_s1_valid),
        .i_s1       (r_s1),
        .o_s2_valid (w_s2_valid),
        .o_s2       (w_s2)
    );

    // Average, threshold test and result register.
    slat_avg u_avg (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_load           (w_adv3),
        .i_valid          (w_s2_valid),
        .i_s2             (w_s2),
        .i_thr_scaled     (r_thr_scaled),
        .o_valid          (o_out_valid),
        .o_accepted       (o_accepted),
        .o_last_level     (o_last_level_q4),
        .o_average_level  (o_average_level_q4),
        .o_over_threshold (o_over_threshold)
    );

    // Input stalls only when every stage holds a request and the output waits.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && w_s2_valid && o_out_valid && i_out_stall))
        else $error("input stalled while the pipeline has room");

endmodule

`default_nettype wire
